[src/frame_ring_bump_allocator_assert.svh]
// Assertion helpers for the frame ring bump allocator.
// Both expect clk and rst_n in scope.
`ifndef FRAME_RING_BUMP_ALLOCATOR_ASSERT_SVH
`define FRAME_RING_BUMP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FRBA_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frba assertion failed");

// next-cycle implication
`define FRBA_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frba assertion failed");

`endif

[src/frba_pkg.sv]
package frba_pkg;

  localparam int MAX_BUFFERS_DEF = 16;
  localparam int REGIONS_DEF     = 3;

  localparam int OP_W     = 2;
  localparam int SIZE_W   = 24;
  localparam int FIDX_W   = 2;
  localparam int STATUS_W = 2;
  localparam int BIDX_W   = 4;
  localparam int WORD_W   = 32;
  localparam int MADE_W   = 5;

  localparam logic [WORD_W-1:0] POOL_RESET = 32'd4194304;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

endpackage

[src/frba_if.sv]
interface frba_in_if;
  logic                             valid;
  logic                             ready;
  logic [frba_pkg::OP_W-1:0]        operation;
  logic [frba_pkg::SIZE_W-1:0]      data_size;
  logic [frba_pkg::FIDX_W-1:0]      frame_index;

  modport source (output valid, operation, data_size, frame_index, input ready);
  modport sink   (input valid, operation, data_size, frame_index, output ready);
endinterface

interface frba_out_if;
  logic                             valid;
  logic                             ready;
  logic [frba_pkg::STATUS_W-1:0]    status;
  logic [frba_pkg::BIDX_W-1:0]      buffer_index;
  logic [frba_pkg::WORD_W-1:0]      byte_offset;
  logic [frba_pkg::WORD_W-1:0]      frame_used;
  logic [frba_pkg::WORD_W-1:0]      peak_frame;
  logic [frba_pkg::MADE_W-1:0]      buffers_made;

  modport source (output valid, status, buffer_index, byte_offset, frame_used, peak_frame,
                  buffers_made, input ready);
  modport sink   (input valid, status, buffer_index, byte_offset, frame_used, peak_frame,
                  buffers_made, output ready);
endinterface

interface frba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [frba_pkg::WORD_W-1:0]      pool_bytes;

  modport source (output valid, pool_bytes, input ready);
  modport sink   (input valid, pool_bytes, output ready);
endinterface

[src/frba_ram.sv]
module frba_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/frba_div.sv]
// Divide by a small constant through a multiply by its rounded-up reciprocal.
// Exact for every Width-bit dividend at the small divisors used for the region count.
// The dividend is registered on start, then the quotient is registered with done.
module frba_div #(
  parameter int Width   = 32,
  parameter int Divisor = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [Width-1:0] dividend,
  output logic             done,
  output logic [Width-1:0] quotient
);

  localparam int PW = 2 * Width;
  localparam int SH = Width + $clog2(Divisor) - 1;
  localparam logic [PW-1:0] RECIP_W = ((PW'(1) << SH) + PW'(Divisor - 1)) / PW'(Divisor);
  localparam logic [Width-1:0] RECIP = RECIP_W[Width-1:0];

  logic             busy_r;
  logic             done_r;
  logic [Width-1:0] d_r;
  logic [Width-1:0] q_r;
  logic [PW-1:0]    prod;

  assign prod = {{Width{1'b0}}, d_r} * {{Width{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
      if (start) begin
        d_r <= dividend;
      end
      if (busy_r) begin
        q_r <= Width'(prod >> SH);
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[src/frame_ring_bump_allocator.sv]
// Frame ring bump allocator.
// in_ch  : one item per transfer (operation, data_size, frame_index); ready only while idle.
// out_ch : exactly one result per item, held in an output register until transferred.
// cfg_ch : pool_bytes write, always ready; write only while the block is idle.
// Every buffer is cut into REGIONS equal regions, one per in-flight frame; region
// pointers live in a RAM of MAX_BUFFERS*4 words, region sizes in a small register file.
// Steps from input transfer to output valid, with N buffers in use:
//   allocate landing in buffer k        : decode, read + compare for buffers 0..k
//   allocate that creates a new buffer  : scan all N, divide by REGIONS, rewind regions
//   allocate with the pool exhausted    : scan of all N buffers
//   begin frame                         : one region rewrite per buffer, one per cycle
//   reset all                           : every region of every buffer, one per cycle
//   zero size, bad frame index, other   : decode only
// One item is in flight at a time; the next input can be taken as output valid rises,
// even while the previous result still waits in the output register.
// A stalled output only holds the sequencer in its final step until the transfer.
// Reset empties the buffer list, zeroes the counters and sets pool_bytes to 4 MiB;
// the block is ready in the first cycle after reset.
module frame_ring_bump_allocator #(
  parameter int MAX_BUFFERS = frba_pkg::MAX_BUFFERS_DEF,
  parameter int REGIONS     = frba_pkg::REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  frba_in_if.sink     in_ch,
  frba_out_if.source  out_ch,
  frba_cfg_if.sink    cfg_ch
);

  localparam int CW    = $clog2(MAX_BUFFERS + 1);
  localparam int IW    = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int DEPTH = MAX_BUFFERS * 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = frba_pkg::WORD_W;
  localparam int ALW   = frba_pkg::SIZE_W + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_CK = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_NEW     = 4'd5;
  localparam logic [3:0] S_NEWFIT  = 4'd6;
  localparam logic [3:0] S_FRAME   = 4'd7;
  localparam logic [3:0] S_RALL    = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]                      state_r;
  logic [frba_pkg::OP_W-1:0]       op_r;
  logic [ALW-1:0]                  aligned_r;
  logic [frba_pkg::FIDX_W-1:0]     fidx_r;
  logic [CW-1:0]                   idx_r;
  logic [1:0]                      reg_r;
  logic [WW-1:0]                   acc_r;
  logic [WW-1:0]                   start_r;
  logic [WW-1:0]                   rs_r;
  logic [WW-1:0]                   rsize_r [MAX_BUFFERS];

  logic [WW-1:0]                   pool_r;
  logic [CW-1:0]                   buffer_total_r;
  logic [1:0]                      active_r;
  logic [WW-1:0]                   frame_r;
  logic [WW-1:0]                   peak_r;
  logic [WW-1:0]                   alloc_total_r;

  logic [frba_pkg::STATUS_W-1:0]   st_r;
  logic [CW-1:0]                   bidx_r;
  logic [WW-1:0]                   off_r;

  logic                            out_valid_r;
  logic [frba_pkg::STATUS_W-1:0]   out_status_r;
  logic [frba_pkg::BIDX_W-1:0]     out_bidx_r;
  logic [WW-1:0]                   out_off_r;
  logic [WW-1:0]                   out_frame_r;
  logic [WW-1:0]                   out_peak_r;
  logic [frba_pkg::MADE_W-1:0]     out_made_r;

  logic                            ram_we;
  logic [AW-1:0]                   ram_wa;
  logic [WW-1:0]                   ram_wd;
  logic [AW-1:0]                   ram_ra;
  logic [WW-1:0]                   ram_q;

  logic                            div_start;
  logic                            div_done;
  logic [WW-1:0]                   div_q;

  logic [WW-1:0]                   aligned32;
  logic [WW-1:0]                   rs_idx;
  logic [WW-1:0]                   used;
  logic                            fit;
  logic                            new_fit;
  logic [WW-1:0]                   round64k;
  logic [WW-1:0]                   nsize;
  logic [WW:0]                     frame_sum;
  logic [WW-1:0]                   frame_sat;
  logic [WW-1:0]                   alloc_sat;
  logic [WW-1:0]                   peak_max;
  logic                            at_end;
  logic                            out_free;

  assign aligned32 = WW'(aligned_r);
  assign rs_idx    = rsize_r[idx_r[IW-1:0]];
  assign at_end    = (idx_r == buffer_total_r);

  // room check: used + aligned must stay within the region size
  assign used      = (ram_q >= start_r) ? (ram_q - start_r) : '0;
  assign fit       = ({1'b0, used} + {1'b0, aligned32}) <= {1'b0, rs_r};
  assign new_fit   = (aligned32 <= rs_r);

  assign round64k  = (aligned32 + 32'd65535) & 32'hFFFF_0000;
  assign nsize     = (aligned32 > pool_r) ? round64k : pool_r;

  assign frame_sum = {1'b0, frame_r} + {1'b0, aligned32};
  assign frame_sat = frame_sum[WW] ? '1 : frame_sum[WW-1:0];
  assign alloc_sat = (alloc_total_r == '1) ? alloc_total_r : alloc_total_r + 1'b1;
  assign peak_max  = (frame_r > peak_r) ? frame_r : peak_r;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign ram_ra    = {idx_r[IW-1:0], active_r};

  always_comb begin
    ram_we    = 1'b0;
    ram_wa    = {idx_r[IW-1:0], active_r};
    ram_wd    = ram_q + aligned32;
    div_start = 1'b0;
    case (state_r)
      S_SCAN_RD: begin
        div_start = at_end && (buffer_total_r < CW'(MAX_BUFFERS));
      end
      S_SCAN_CK: begin
        ram_we = fit;
      end
      S_NEW: begin
        ram_we = 1'b1;
        ram_wa = {idx_r[IW-1:0], reg_r};
        ram_wd = acc_r;
      end
      S_NEWFIT: begin
        ram_we = new_fit;
        ram_wd = start_r + aligned32;
      end
      S_FRAME: begin
        ram_we = !at_end;
        ram_wa = {idx_r[IW-1:0], fidx_r};
        ram_wd = WW'(rs_idx * WW'(fidx_r));
      end
      S_RALL: begin
        ram_we = !at_end;
        ram_wa = {idx_r[IW-1:0], reg_r};
        ram_wd = acc_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  frba_ram #(
    .Width (WW),
    .Depth (DEPTH)
  ) u_region_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_q)
  );

  frba_div #(
    .Width   (WW),
    .Divisor (REGIONS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (nsize),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      pool_r         <= frba_pkg::POOL_RESET;
      buffer_total_r <= '0;
      active_r       <= '0;
      frame_r        <= '0;
      peak_r         <= '0;
      alloc_total_r  <= '0;
    end else begin
      if (cfg_ch.valid) begin
        pool_r <= cfg_ch.pool_bytes;
      end
      // S_DONE reloads the output register itself
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r      <= in_ch.operation;
            aligned_r <= ({1'b0, in_ch.data_size} + ALW'(255)) & ~ALW'(255);
            fidx_r    <= in_ch.frame_index;
            state_r   <= S_DECODE;
          end
        end
        S_DECODE: begin
          bidx_r <= '0;
          off_r  <= '0;
          idx_r  <= '0;
          reg_r  <= '0;
          acc_r  <= '0;
          case (op_r)
            frba_pkg::OP_ALLOC: begin
              if (aligned_r == '0) begin
                st_r    <= frba_pkg::ST_ZERO;
                state_r <= S_DONE;
              end else begin
                st_r    <= frba_pkg::ST_OK;
                state_r <= S_SCAN_RD;
              end
            end
            frba_pkg::OP_BEGIN: begin
              if (3'(fidx_r) >= 3'(REGIONS)) begin
                st_r    <= frba_pkg::ST_BAD_FRAME;
                state_r <= S_DONE;
              end else begin
                st_r    <= frba_pkg::ST_OK;
                state_r <= S_FRAME;
              end
            end
            frba_pkg::OP_RESET: begin
              st_r    <= frba_pkg::ST_OK;
              state_r <= S_RALL;
            end
            default: begin
              st_r    <= frba_pkg::ST_OK;
              state_r <= S_DONE;
            end
          endcase
        end
        S_SCAN_RD: begin
          if (at_end) begin
            if (buffer_total_r < CW'(MAX_BUFFERS)) begin
              state_r <= S_DIV;
            end else begin
              st_r    <= frba_pkg::ST_EXHAUSTED;
              state_r <= S_DONE;
            end
          end else begin
            start_r <= WW'(rs_idx * WW'(active_r));
            rs_r    <= rs_idx;
            state_r <= S_SCAN_CK;
          end
        end
        S_SCAN_CK: begin
          if (fit) begin
            bidx_r        <= idx_r;
            off_r         <= ram_q;
            frame_r       <= frame_sat;
            alloc_total_r <= alloc_sat;
            state_r       <= S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN_RD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rs_r                     <= div_q;
            rsize_r[idx_r[IW-1:0]]   <= div_q;
            acc_r                    <= '0;
            reg_r                    <= '0;
            state_r                  <= S_NEW;
          end
        end
        S_NEW: begin
          // rewind every region of the fresh buffer, remember the active one's base
          if (reg_r == active_r) begin
            start_r <= acc_r;
          end
          acc_r <= acc_r + rs_r;
          if (reg_r == 2'(REGIONS - 1)) begin
            state_r <= S_NEWFIT;
          end else begin
            reg_r <= reg_r + 1'b1;
          end
        end
        S_NEWFIT: begin
          buffer_total_r <= buffer_total_r + 1'b1;
          if (new_fit) begin
            bidx_r        <= idx_r;
            off_r         <= start_r;
            frame_r       <= frame_sat;
            alloc_total_r <= alloc_sat;
          end else begin
            st_r <= frba_pkg::ST_EXHAUSTED;
          end
          state_r <= S_DONE;
        end
        S_FRAME: begin
          if (at_end) begin
            frame_r  <= '0;
            active_r <= fidx_r;
            state_r  <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_RALL: begin
          if (at_end) begin
            frame_r <= '0;
            state_r <= S_DONE;
          end else if (reg_r == 2'(REGIONS - 1)) begin
            reg_r <= '0;
            acc_r <= '0;
            idx_r <= idx_r + 1'b1;
          end else begin
            reg_r <= reg_r + 1'b1;
            acc_r <= acc_r + rs_idx;
          end
        end
        S_DONE: begin
          if (out_free) begin
            peak_r       <= peak_max;
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_bidx_r   <= frba_pkg::BIDX_W'(bidx_r);
            out_off_r    <= off_r;
            out_frame_r  <= frame_r;
            out_peak_r   <= peak_max;
            out_made_r   <= frba_pkg::MADE_W'(buffer_total_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.buffer_index = out_bidx_r;
  assign out_ch.byte_offset  = out_off_r;
  assign out_ch.frame_used   = out_frame_r;
  assign out_ch.peak_frame   = out_peak_r;
  assign out_ch.buffers_made = out_made_r;

`include "frame_ring_bump_allocator_assert.svh"

  `FRBA_AST_NXT(a_accept_decodes, in_ch.valid && in_ch.ready, state_r == S_DECODE)
  `FRBA_AST_IMP(a_total_bounded, 1'b1, buffer_total_r <= CW'(MAX_BUFFERS))
  `FRBA_AST_IMP(a_active_in_ring, 1'b1, 3'(active_r) < 3'(REGIONS))
  `FRBA_AST_IMP(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE)

endmodule
